// ===== rtl/core/pia_pkg.sv =====
// Shared types and constants of the peripheral interface adapter.
package pia_pkg;

	typedef enum logic [3:0] {
		OP_READ      = 4'd0,
		OP_WRITE     = 4'd1,
		OP_CA1       = 4'd2,
		OP_CA2       = 4'd3,
		OP_CB1       = 4'd4,
		OP_CB2       = 4'd5,
		OP_PINS_A    = 4'd6,
		OP_PINS_B    = 4'd7,
		OP_TICK      = 4'd8,
		OP_RESET_LN  = 4'd9
	} op_t;

	localparam logic [1:0] RS_PORT_A = 2'd0;
	localparam logic [1:0] RS_CTRL_A = 2'd1;
	localparam logic [1:0] RS_PORT_B = 2'd2;
	localparam logic [1:0] RS_CTRL_B = 2'd3;

	// control register bit positions
	localparam int CTRL_IRQ1_EN    = 0;
	localparam int CTRL_LINE1_RISE = 1;
	localparam int CTRL_DATA_SEL   = 2;
	localparam int CTRL_IRQ2_EN    = 3;
	localparam int CTRL_LINE2_RISE = 4;
	localparam int CTRL_LINE2_OUT  = 5;

	// line-2 modes, control bits 5..3
	localparam logic [2:0] MODE_HANDSHAKE = 3'd4;
	localparam logic [2:0] MODE_PULSE     = 3'd5;
	localparam logic [2:0] MODE_LOW       = 3'd6;
	localparam logic [2:0] MODE_HIGH      = 3'd7;

	localparam logic [7:0] READ_IDLE = 8'hFF;
	localparam logic [7:0] PINS_RESET = 8'hFF;

	typedef struct packed {
		logic [3:0] opcode;
		logic [1:0] reg_select;
		logic [7:0] write_data;
		logic       line_level;
		logic [7:0] elapsed_cycles;
	} item_t;

	typedef struct packed {
		logic [7:0] port_b_dirs;
		logic [7:0] port_b_latch;
		logic [7:0] port_a_dirs;
		logic [7:0] port_a_latch;
		logic       cb2_level;
		logic       ca2_level;
		logic       irq_b;
		logic       irq_a;
		logic [7:0] read_data;
	} result_t;

endpackage

// ===== rtl/core/pia_core.sv =====
// Register file of the adapter and the next-state logic for one event.
module pia_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  pia_pkg::item_t     item,
	output pia_pkg::result_t   result
);

	logic [1:0][7:0] out_q, dir_q, pins_q;
	logic [1:0][5:0] ctrl_q;
	logic [1:0][1:0] lines_q, flags_q;   // [side][0] line/flag 1, [side][1] line/flag 2
	logic [1:0]      drive_q, pend_q;
	logic            rst_lvl_q;

	logic [1:0][7:0] out_n, dir_n, pins_n;
	logic [1:0][5:0] ctrl_n;
	logic [1:0][1:0] lines_n, flags_n;
	logic [1:0]      drive_n, pend_n;
	logic            rst_lvl_n;
	logic [7:0]      rd;
	logic            side, which, prev, rise_sel, hit;
	logic [2:0]      md;
	logic [1:0]      irq;

	always_comb begin
		out_n     = out_q;
		dir_n     = dir_q;
		pins_n    = pins_q;
		ctrl_n    = ctrl_q;
		lines_n   = lines_q;
		flags_n   = flags_q;
		drive_n   = drive_q;
		pend_n    = pend_q;
		rst_lvl_n = rst_lvl_q;
		rd        = pia_pkg::READ_IDLE;
		prev      = 1'b0;
		rise_sel  = 1'b0;
		hit       = 1'b0;
		md        = 3'd0;

		// bus accesses pick the side from the register select, line events from the opcode
		if (item.opcode == pia_pkg::OP_READ || item.opcode == pia_pkg::OP_WRITE) begin
			side  = item.reg_select[1];
			which = 1'b0;
		end else begin
			side  = (item.opcode == pia_pkg::OP_CB1) || (item.opcode == pia_pkg::OP_CB2);
			which = (item.opcode == pia_pkg::OP_CA2) || (item.opcode == pia_pkg::OP_CB2);
		end

		unique case (item.opcode)
			pia_pkg::OP_READ: begin
				if (item.reg_select[0]) begin
					rd = {flags_q[side][0], flags_q[side][1], ctrl_q[side]};
				end else if (!ctrl_q[side][pia_pkg::CTRL_DATA_SEL]) begin
					rd = dir_q[side];
				end else begin
					rd = (out_q[side] & dir_q[side]) | (pins_q[side] & ~dir_q[side]);
					flags_n[side] = 2'b00;
					// only a port A read starts the CA2 handshake
					if (!side) begin
						md = ctrl_q[0][5:3];
						if (md == pia_pkg::MODE_HANDSHAKE) begin
							drive_n[0] = 1'b0;
						end else if (md == pia_pkg::MODE_PULSE) begin
							drive_n[0] = 1'b0;
							pend_n[0]  = 1'b1;
						end
					end
				end
			end
			pia_pkg::OP_WRITE: begin
				if (item.reg_select[0]) begin
					ctrl_n[side] = item.write_data[5:0];
					md           = item.write_data[5:3];
					pend_n[side] = 1'b0;
					if (md[2])
						flags_n[side][1] = 1'b0;
					if (md == pia_pkg::MODE_HANDSHAKE || md == pia_pkg::MODE_PULSE ||
					    md == pia_pkg::MODE_HIGH)
						drive_n[side] = 1'b1;
					else if (md == pia_pkg::MODE_LOW)
						drive_n[side] = 1'b0;
				end else if (!ctrl_q[side][pia_pkg::CTRL_DATA_SEL]) begin
					dir_n[side] = item.write_data;
				end else begin
					out_n[side] = item.write_data;
					// only a port B write starts the CB2 handshake
					if (side) begin
						md = ctrl_q[1][5:3];
						if (md == pia_pkg::MODE_HANDSHAKE) begin
							drive_n[1] = 1'b0;
						end else if (md == pia_pkg::MODE_PULSE) begin
							drive_n[1] = 1'b0;
							pend_n[1]  = 1'b1;
						end
					end
				end
			end
			pia_pkg::OP_CA1, pia_pkg::OP_CA2, pia_pkg::OP_CB1, pia_pkg::OP_CB2: begin
				// line 2 in an output mode ignores input events entirely
				if (!(which && ctrl_q[side][pia_pkg::CTRL_LINE2_OUT])) begin
					prev     = lines_q[side][which];
					rise_sel = which ? ctrl_q[side][pia_pkg::CTRL_LINE2_RISE]
					                 : ctrl_q[side][pia_pkg::CTRL_LINE1_RISE];
					hit      = rise_sel ? (!prev && item.line_level) : (prev && !item.line_level);
					lines_n[side][which] = item.line_level;
					if (hit) begin
						flags_n[side][which] = 1'b1;
						if (!which && ctrl_q[side][5:3] == pia_pkg::MODE_HANDSHAKE)
							drive_n[side] = 1'b1;
					end
				end
			end
			pia_pkg::OP_PINS_A: pins_n[0] = item.write_data;
			pia_pkg::OP_PINS_B: pins_n[1] = item.write_data;
			pia_pkg::OP_TICK: begin
				if (item.elapsed_cycles != 8'd0) begin
					drive_n = drive_q | pend_q;
					pend_n  = 2'b00;
				end
			end
			pia_pkg::OP_RESET_LN: begin
				if (item.line_level != rst_lvl_q) begin
					rst_lvl_n = item.line_level;
					if (!item.line_level) begin
						out_n   = '0;
						dir_n   = '0;
						ctrl_n  = '0;
						lines_n = '0;
						flags_n = '0;
						drive_n = '0;
						pend_n  = '0;
					end
				end
			end
			default: ;
		endcase

		for (int s = 0; s < 2; s++) begin
			irq[s] = (flags_n[s][0] & ctrl_n[s][pia_pkg::CTRL_IRQ1_EN]) |
			         (~ctrl_n[s][pia_pkg::CTRL_LINE2_OUT] & flags_n[s][1] &
			          ctrl_n[s][pia_pkg::CTRL_IRQ2_EN]);
		end

		result.read_data    = rd;
		result.irq_a        = irq[0];
		result.irq_b        = irq[1];
		result.ca2_level    = drive_n[0];
		result.cb2_level    = drive_n[1];
		result.port_a_latch = out_n[0];
		result.port_a_dirs  = dir_n[0];
		result.port_b_latch = out_n[1];
		result.port_b_dirs  = dir_n[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q     <= '0;
			dir_q     <= '0;
			pins_q    <= {pia_pkg::PINS_RESET, pia_pkg::PINS_RESET};
			ctrl_q    <= '0;
			lines_q   <= '0;
			flags_q   <= '0;
			drive_q   <= '0;
			pend_q    <= '0;
			rst_lvl_q <= 1'b1;
		end else if (step) begin
			out_q     <= out_n;
			dir_q     <= dir_n;
			pins_q    <= pins_n;
			ctrl_q    <= ctrl_n;
			lines_q   <= lines_n;
			flags_q   <= flags_n;
			drive_q   <= drive_n;
			pend_q    <= pend_n;
			rst_lvl_q <= rst_lvl_n;
		end
	end

endmodule

// ===== rtl/core/peripheral_interface_adapter.sv =====
// An accepted input beat is registered in the input register, and its result in the result register.
// Throughput: one event per cycle while m_axis_tready is high; the input register and the result
// register let a new beat in while the previous result waits for m_axis_tready.
// Each event is settled in the single logic stage between those two registers.
// Reset (arst_n low): registers, flags and line drives clear, pins read all ones.
module peripheral_interface_adapter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // write_data[7:0], line_level[8], elapsed_cycles[16:9]
	input  logic [5:0]  s_axis_tuser,  // opcode[3:0], reg_select[5:4]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // read_data[7:0], irq_a[8], irq_b[9], ca2_level[10],
	                                   // cb2_level[11], port_a_latch[19:12], port_a_dirs[27:20],
	                                   // port_b_latch[35:28], port_b_dirs[43:36]
);

	pia_pkg::item_t   item_s1, item_in;
	pia_pkg::result_t res_comb, res_q;
	logic             valid_s1, out_valid_q, advance;

	assign item_in.opcode         = s_axis_tuser[3:0];
	assign item_in.reg_select     = s_axis_tuser[5:4];
	assign item_in.write_data     = s_axis_tdata[7:0];
	assign item_in.line_level     = s_axis_tdata[8];
	assign item_in.elapsed_cycles = s_axis_tdata[16:9];

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			item_s1 <= item_in;
		if (advance)
			res_q <= res_comb;
	end

	pia_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (res_comb)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, res_q};

endmodule

// ===== dv/peripheral_interface_adapter_tb.sv =====
`timescale 1ns / 1ps
// Stream testbench for the peripheral interface adapter: event table, random events, predictor.
module peripheral_interface_adapter_tb;
	import pia_pkg::*;

	localparam int         CYCLE_LIMIT    = 600000;
	localparam int         RANDOM_ITEMS   = 1450;
	localparam int         RX_HOLD_CYCLES = 300;
	localparam int         DRAIN_CYCLES   = 8;
	localparam logic [3:0] OP_SPARE_FIRST = 4'd10;
	localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

	typedef struct {
		item_t   stim;
		bit      typed;
		result_t want;
	} event_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;
	logic [5:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;

	// shadow of the adapter registers
	logic [7:0] pa_out, pb_out, pa_dir, pb_dir, pa_pins, pb_pins;
	logic [5:0] ctl [2];
	logic [3:0] line_lv, irq_fl;
	logic [1:0] drive2, pulse_pend;
	logic       reset_ln;

	event_row_t event_rows[$];
	event_row_t beats_offered[$];
	result_t    pending_responses[$];
	bit         idle_en     = 1'b1;
	bit         rx_hold_req = 1'b0;
	int         mismatches  = 0;
	int         cycle_count = 0;

	peripheral_interface_adapter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #2 clk = ~clk;

	function automatic logic [2:0] mode_of(int side);
		return ctl[side][5:3];
	endfunction

	function automatic logic irq_of(int side);
		logic [5:0] c;
		c = ctl[side];
		return (irq_fl[2*side] & c[CTRL_IRQ1_EN]) |
			(~c[CTRL_LINE2_OUT] & irq_fl[2*side+1] & c[CTRL_IRQ2_EN]);
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic clear_state();
		pa_out = '0; pb_out = '0; pa_dir = '0; pb_dir = '0;
		ctl[0] = '0; ctl[1] = '0;
		line_lv = '0; drive2 = '0; pulse_pend = '0; irq_fl = '0;
	endtask

	// handshake and pulse modes pull line 2 low on a data access
	task automatic start_low(int side);
		if (mode_of(side) == MODE_HANDSHAKE) begin
			drive2[side] = 1'b0;
		end else if (mode_of(side) == MODE_PULSE) begin
			drive2[side] = 1'b0;
			pulse_pend[side] = 1'b1;
		end
	endtask

	task automatic write_ctrl(int side, logic [7:0] v);
		ctl[side] = v[5:0];
		pulse_pend[side] = 1'b0;
		if (v[CTRL_LINE2_OUT])
			irq_fl[2*side+1] = 1'b0;
		if (mode_of(side) == MODE_HANDSHAKE || mode_of(side) == MODE_PULSE ||
				mode_of(side) == MODE_HIGH)
			drive2[side] = 1'b1;
		else if (mode_of(side) == MODE_LOW)
			drive2[side] = 1'b0;
	endtask

	task automatic predict_response(input item_t it, output result_t res);
		int         side, which, bitn;
		logic [5:0] c;
		logic       rise, hit;
		res = '0;
		res.read_data = READ_IDLE;
		case (it.opcode)
			OP_READ: case (it.reg_select)
				RS_PORT_A: begin
					if (!ctl[0][CTRL_DATA_SEL]) begin
						res.read_data = pa_dir;
					end else begin
						res.read_data = (pa_out & pa_dir) | (pa_pins & ~pa_dir);
						irq_fl[1:0] = 2'b00;
						start_low(0);
					end
				end
				RS_CTRL_A: res.read_data = {irq_fl[0], irq_fl[1], ctl[0]};
				RS_PORT_B: begin
					if (!ctl[1][CTRL_DATA_SEL]) begin
						res.read_data = pb_dir;
					end else begin
						res.read_data = (pb_out & pb_dir) | (pb_pins & ~pb_dir);
						irq_fl[3:2] = 2'b00;
					end
				end
				default: res.read_data = {irq_fl[2], irq_fl[3], ctl[1]};
			endcase
			OP_WRITE: case (it.reg_select)
				RS_PORT_A: begin
					if (ctl[0][CTRL_DATA_SEL])
						pa_out = it.write_data;
					else
						pa_dir = it.write_data;
				end
				RS_CTRL_A: write_ctrl(0, it.write_data);
				RS_PORT_B: begin
					if (ctl[1][CTRL_DATA_SEL]) begin
						pb_out = it.write_data;
						start_low(1);
					end else begin
						pb_dir = it.write_data;
					end
				end
				default: write_ctrl(1, it.write_data);
			endcase
			OP_CA1, OP_CA2, OP_CB1, OP_CB2: begin
				side = (int'(it.opcode) - int'(OP_CA1)) / 2;
				which = (int'(it.opcode) - int'(OP_CA1)) % 2;
				bitn = 2 * side + which;
				c = ctl[side];
				rise = which ? c[CTRL_LINE2_RISE] : c[CTRL_LINE1_RISE];
				// line 2 in an output mode ignores input edges, level included
				if (!(which == 1 && c[CTRL_LINE2_OUT])) begin
					hit = rise ? (!line_lv[bitn] && it.line_level) :
						(line_lv[bitn] && !it.line_level);
					line_lv[bitn] = it.line_level;
					if (hit) begin
						irq_fl[bitn] = 1'b1;
						if (which == 0 && mode_of(side) == MODE_HANDSHAKE)
							drive2[side] = 1'b1;
					end
				end
			end
			OP_PINS_A: pa_pins = it.write_data;
			OP_PINS_B: pb_pins = it.write_data;
			OP_TICK: begin
				if (it.elapsed_cycles != 8'd0) begin
					drive2 = drive2 | pulse_pend;
					pulse_pend = 2'b00;
				end
			end
			OP_RESET_LN: begin
				if (it.line_level != reset_ln) begin
					reset_ln = it.line_level;
					if (!it.line_level)
						clear_state();
				end
			end
			default: ;
		endcase
		res.irq_a = irq_of(0);
		res.irq_b = irq_of(1);
		res.ca2_level = drive2[0];
		res.cb2_level = drive2[1];
		res.port_a_latch = pa_out;
		res.port_a_dirs = pa_dir;
		res.port_b_latch = pb_out;
		res.port_b_dirs = pb_dir;
	endtask

	task automatic add_row(logic [3:0] op, logic [1:0] rs, logic [7:0] wd, logic lvl,
			logic [7:0] el, bit typed, logic [7:0] want_rd, logic [7:0] want_pa_dirs);
		event_row_t row;
		row.stim.opcode = op;
		row.stim.reg_select = rs;
		row.stim.write_data = wd;
		row.stim.line_level = lvl;
		row.stim.elapsed_cycles = el;
		row.typed = typed;
		row.want = '0;
		row.want.read_data = want_rd;
		row.want.port_a_dirs = want_pa_dirs;
		event_rows.push_back(row);
	endtask

	function automatic item_t random_event();
		item_t it;
		int    r;
		it.reg_select = 2'($urandom_range(0, 3));
		it.write_data = 8'($urandom_range(0, 255));
		it.line_level = 1'($urandom_range(0, 1));
		it.elapsed_cycles = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		r = $urandom_range(0, 99);
		if (r < 24)
			it.opcode = OP_READ;
		else if (r < 48)
			it.opcode = OP_WRITE;
		else if (r < 72)
			it.opcode = 4'(int'(OP_CA1) + $urandom_range(0, 3));
		else if (r < 78)
			it.opcode = $urandom_range(0, 1) ? OP_PINS_A : OP_PINS_B;
		else if (r < 92)
			it.opcode = OP_TICK;
		else if (r < 96)
			it.opcode = OP_RESET_LN;
		else
			it.opcode = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		return it;
	endfunction

	// entered and left at a falling edge
	task automatic send_event(input event_row_t row);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		beats_offered.push_back(row);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, row.stim.elapsed_cycles, row.stim.line_level, row.stim.write_data};
		s_axis_tuser <= {row.stim.reg_select, row.stim.opcode};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
				$time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		item_t      seen;
		result_t    want, got;
		event_row_t note;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				seen.opcode = s_axis_tuser[3:0];
				seen.reg_select = s_axis_tuser[5:4];
				seen.write_data = s_axis_tdata[7:0];
				seen.line_level = s_axis_tdata[8];
				seen.elapsed_cycles = s_axis_tdata[16:9];
				note = beats_offered.pop_front();
				predict_response(seen, want);
				pending_responses.push_back(note.typed ? note.want : want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[43:0]);
				if (pending_responses.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with none expected, expected nothing, actual 0x%011h",
						$time, m_axis_tdata[43:0]);
				end else begin
					want = pending_responses.pop_front();
					check_field("read_data", want.read_data, got.read_data);
					check_field("irq_a", 8'(want.irq_a), 8'(got.irq_a));
					check_field("irq_b", 8'(want.irq_b), 8'(got.irq_b));
					check_field("ca2_level", 8'(want.ca2_level), 8'(got.ca2_level));
					check_field("cb2_level", 8'(want.cb2_level), 8'(got.cb2_level));
					check_field("port_a_latch", want.port_a_latch, got.port_a_latch);
					check_field("port_a_dirs", want.port_a_dirs, got.port_a_dirs);
					check_field("port_b_latch", want.port_b_latch, got.port_b_latch);
					check_field("port_b_dirs", want.port_b_dirs, got.port_b_dirs);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("peripheral_interface_adapter test failed");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
			end else if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin
		event_row_t row;
		clear_state();
		pa_pins = PINS_RESET;
		pb_pins = PINS_RESET;
		reset_ln = 1'b1;

		// reset values, then the widest fields
		add_row(OP_READ, RS_CTRL_A, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 8'h00);
		add_row(OP_READ, RS_CTRL_B, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 8'h00);
		add_row(OP_READ, RS_PORT_B, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 8'h00);
		add_row(OP_WRITE, RS_PORT_A, 8'hFF, 1'b0, 8'h00, 1'b1, READ_IDLE, 8'hFF);
		add_row(OP_SPARE_LAST, RS_CTRL_B, 8'hFF, 1'b1, 8'hFF, 1'b1, READ_IDLE, 8'hFF);
		// CA1 rising edge with interrupt enabled, flag read back and cleared
		add_row(OP_WRITE, RS_CTRL_A, 8'h07, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_WRITE, RS_PORT_A, 8'hA5, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_PINS_A, RS_PORT_A, 8'h3C, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_CA1, RS_PORT_A, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_READ, RS_CTRL_A, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_READ, RS_PORT_A, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		// handshake on A: read pulls CA2 low, CA1 falling edge releases it
		add_row(OP_WRITE, RS_CTRL_A, 8'h24, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_READ, RS_PORT_A, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_CA1, RS_PORT_A, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		// CA2 as input, rising edge, interrupt enabled
		add_row(OP_WRITE, RS_CTRL_A, 8'h1C, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_CA2, RS_PORT_A, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 8'h00);
		// pulse on B: zero tick keeps it, a tick of one ends it
		add_row(OP_WRITE, RS_CTRL_B, 8'h2C, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_WRITE, RS_PORT_B, 8'h5A, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_TICK, RS_PORT_A, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_TICK, RS_PORT_A, 8'h00, 1'b0, 8'h01, 1'b0, 8'h00, 8'h00);
		add_row(OP_CB1, RS_PORT_A, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_CB1, RS_PORT_A, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		// forced low and high on CB2, input edge ignored there
		add_row(OP_WRITE, RS_CTRL_B, 8'h31, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_PINS_B, RS_PORT_A, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_READ, RS_PORT_B, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_WRITE, RS_CTRL_B, 8'h3C, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		add_row(OP_CB2, RS_PORT_A, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 8'h00);
		// reset line: falling clears, a repeated level does nothing
		add_row(OP_RESET_LN, RS_PORT_A, 8'h00, 1'b0, 8'h00, 1'b1, READ_IDLE, 8'h00);
		add_row(OP_RESET_LN, RS_PORT_A, 8'h00, 1'b0, 8'h00, 1'b1, READ_IDLE, 8'h00);
		add_row(OP_RESET_LN, RS_PORT_A, 8'h00, 1'b1, 8'h00, 1'b1, READ_IDLE, 8'h00);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (event_rows[i])
			send_event(event_rows[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				idle_en = ($urandom_range(0, 3) != 0);
			if (n == 400)
				rx_hold_req = 1'b1;
			if (n == 900) begin
				s_axis_tvalid <= 1'b0;
				wait (pending_responses.size() == 0);
				@(negedge clk);
			end
			row.stim = random_event();
			row.typed = 1'b0;
			row.want = '0;
			send_event(row);
		end
		s_axis_tvalid <= 1'b0;

		wait (pending_responses.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("peripheral_interface_adapter test passed");
		else
			$display("peripheral_interface_adapter test failed");
		$finish;
	end

endmodule
